/* rtl/gbnq_pkg.sv */
// ----------------------------------------------------------------------------
// gbnq_pkg
// Shared types, constants and helpers of the grid bucket neighbour query block.
// ----------------------------------------------------------------------------
package gbnq_pkg;

  // grid geometry
  localparam int GRID_ROWS    = 16;
  localparam int GRID_COLS    = 16;
  localparam int BUCKET_DEPTH = 4;

  localparam int GRID_MAX   = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
  localparam int CNT_W      = $clog2(GRID_MAX + 1);
  localparam int CELL_TOTAL = GRID_ROWS * GRID_COLS;
  localparam int CELL_W     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
  localparam int FILL_W     = $clog2(BUCKET_DEPTH + 1);
  localparam int IDX_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int ID_DEPTH   = CELL_TOTAL * BUCKET_DEPTH;
  localparam int IDA_W      = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;
  localparam int AEXT_W     = CELL_W + 4;
  localparam int PROD_W     = 2 * CNT_W + 1;

  // field widths
  localparam int ID_W      = 16;
  localparam int OCELL_W   = 8;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  // commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_NBR     = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;
  localparam logic [1:0] KIND_DROPPED = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MIN_X     = 3'd0;
  localparam logic [2:0] REG_MIN_Y     = 3'd1;
  localparam logic [2:0] REG_ROW_SCALE = 3'd2;
  localparam logic [2:0] REG_COL_SCALE = 3'd3;
  localparam logic [2:0] REG_ROW_COUNT = 3'd4;
  localparam logic [2:0] REG_COL_COUNT = 3'd5;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [ID_W-1:0]    item_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_W-1:0]    found_id;
    logic [OCELL_W-1:0] cell_index;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic [31:0]        row_scale;
    logic [31:0]        col_scale;
    logic [4:0]         row_count;
    logic [4:0]         col_count;
  } cfg_regs_t;

  // effective grid shape
  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
  } shape_t;

  // mapped row / column of the current point
  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
  } pos_t;

  // zero acts as one, anything above the bound as the bound
  function automatic logic [CNT_W-1:0] eff_count(input logic [4:0] c,
                                                 input logic [CNT_W-1:0] bound);
    logic [CNT_W-1:0] res;
    if (c == 5'd0) begin
      res = CNT_W'(1);
    end else if (8'(c) > 8'(bound)) begin
      res = bound;
    end else begin
      res = CNT_W'(c);
    end
    return res;
  endfunction

  // floor of the product, clamped to n-1
  function automatic logic [CNT_W-1:0] axis_clamp(input logic [27:0] p,
                                                  input logic [CNT_W-1:0] n);
    logic [27:0]      lim;
    logic [CNT_W-1:0] res;
    lim = 28'(n) - 28'd1;
    if (p > lim) begin
      res = n - CNT_W'(1);
    end else begin
      res = p[CNT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c,
                                                input logic [CNT_W-1:0] cols);
    logic [PROD_W-1:0] s;
    s = PROD_W'(r) * PROD_W'(cols) + PROD_W'(c);
    return s[CELL_W-1:0];
  endfunction

  function automatic logic [IDA_W-1:0] id_addr(input logic [CELL_W-1:0] cell_no,
                                               input logic [FILL_W-1:0] idx);
    logic [AEXT_W-1:0] t;
    t = AEXT_W'(cell_no) * AEXT_W'(BUCKET_DEPTH) + AEXT_W'(idx);
    return t[IDA_W-1:0];
  endfunction

  function automatic logic [OCELL_W-1:0] out_cell(input logic [CELL_W-1:0] cell_no);
    logic [CELL_W+OCELL_W-1:0] t;
    t = {{OCELL_W{1'b0}}, cell_no};
    return t[OCELL_W-1:0];
  endfunction

endpackage

/* rtl/gbnq_ram.sv */
// ----------------------------------------------------------------------------
// gbnq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbnq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gbnq_cell_map.sv */
// ----------------------------------------------------------------------------
// gbnq_cell_map
// Maps a point to grid row and column: offset, scale multiply, floor, clamp.
// ----------------------------------------------------------------------------
module gbnq_cell_map
  import gbnq_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  cfg_regs_t          cfg,
  input  shape_t             shape,
  output pos_t               pos
);

  logic signed [32:0] dx_r, dy_r;
  logic [63:0]        prod_x_r, prod_y_r;
  logic               dx_pos, dy_pos;

  // offsets are exact in 33 bits
  always_ff @(posedge clk) begin
    if (load) begin
      dx_r <= {x[31], x} - {cfg.min_x[31], cfg.min_x};
      dy_r <= {y[31], y} - {cfg.min_y[31], cfg.min_y};
    end
  end

  assign dx_pos = !dx_r[32] && (dx_r != '0);
  assign dy_pos = !dy_r[32] && (dy_r != '0);

  // a positive offset fits in 32 bits unsigned
  always_ff @(posedge clk) begin
    prod_x_r <= dx_pos ? 64'(dx_r[31:0]) * 64'(cfg.row_scale) : '0;
    prod_y_r <= dy_pos ? 64'(dy_r[31:0]) * 64'(cfg.col_scale) : '0;
  end

  // Q.20 times Q.16 leaves 36 fraction bits
  assign pos.row = axis_clamp(prod_x_r[63:36], shape.rows);
  assign pos.col = axis_clamp(prod_y_r[63:36], shape.cols);

endmodule

/* rtl/gbnq_seq.sv */
// ----------------------------------------------------------------------------
// gbnq_seq
// Command sequencer around the fill and id memories, with output staging.
// ----------------------------------------------------------------------------
module gbnq_seq
  import gbnq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  shape_t    shape,
  input  pos_t      pos,
  output logic      map_load
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CELL = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_NB   = 3'd4;
  localparam logic [2:0] S_NBF  = 3'd5;
  localparam logic [2:0] S_ID   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [1:0]            cmd_r, cmd_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [CNT_W-1:0]      row_r, row_nxt;
  logic [CNT_W-1:0]      col_r, col_nxt;
  logic [CELL_W-1:0]     cell_r, cell_nxt;
  logic [CELL_W-1:0]     sel_r, sel_nxt;
  logic [IDX_W-1:0]      i_r, i_nxt;
  logic [1:0]            dr_r, dr_nxt;
  logic [1:0]            dc_r, dc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  out_item_t             pend_r, pend_nxt;
  logic [CELL_TOTAL-1:0] vld_r, vld_nxt;

  logic                  accept, out_free, adv;
  logic [CELL_W-1:0]     cell_now;
  logic [FILL_W-1:0]     fill_rdata, fill_cur, fill_wdata;
  logic                  fill_we;
  logic [ID_W-1:0]       ids_rdata;
  logic                  ids_we;
  logic [CNT_W:0]        nr_ext, nc_ext, nr_m1, nc_m1;
  logic                  nb_ok;
  logic [CELL_W-1:0]     nb_cell;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign map_load  = accept;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign cell_now = cell_of(pos.row, pos.col, shape.cols);

  // fill of the bucket under sel_r; never-written buckets read as empty
  assign fill_cur = vld_r[sel_r] ? fill_rdata : '0;

  // neighbour at offset (dr-1, dc-1)
  assign nr_ext  = {1'b0, row_r} + (CNT_W+1)'(dr_r);
  assign nc_ext  = {1'b0, col_r} + (CNT_W+1)'(dc_r);
  assign nr_m1   = nr_ext - (CNT_W+1)'(1);
  assign nc_m1   = nc_ext - (CNT_W+1)'(1);
  assign nb_ok   = (nr_ext != '0) && (nr_ext <= {1'b0, shape.rows}) &&
                   (nc_ext != '0) && (nc_ext <= {1'b0, shape.cols});
  assign nb_cell = cell_of(nr_m1[CNT_W-1:0], nc_m1[CNT_W-1:0], shape.cols);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    cell_nxt       = cell_r;
    sel_nxt        = sel_r;
    i_nxt          = i_r;
    dr_nxt         = dr_r;
    dc_nxt         = dc_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    vld_nxt        = vld_r;
    fill_we        = 1'b0;
    fill_wdata     = fill_cur + FILL_W'(1);
    ids_we         = 1'b0;
    adv            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_data.command;
          id_nxt    = in_data.item_id;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_CELL;
      end
      S_CELL: begin
        row_nxt  = pos.row;
        col_nxt  = pos.col;
        cell_nxt = cell_now;
        sel_nxt  = cell_now;
        dr_nxt   = 2'd0;
        dc_nxt   = 2'd0;
        case (cmd_r)
          CMD_INSERT: begin
            state_nxt = S_INS;
          end
          CMD_QUERY: begin
            state_nxt = S_NB;
          end
          CMD_CLEAR: begin
            if (out_free) begin
              vld_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = '{kind: KIND_ACK, found_id: '0, cell_index: '0, last: 1'b1};
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{kind: KIND_ACK, found_id: '0, cell_index: '0, last: 1'b1};
              state_nxt     = S_IDLE;
            end
          end
        endcase
      end
      S_INS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (fill_cur < FILL_W'(BUCKET_DEPTH)) begin
            ids_we         = 1'b1;
            fill_we        = 1'b1;
            vld_nxt[sel_r] = 1'b1;
            out_nxt = '{kind: KIND_ACK, found_id: '0, cell_index: out_cell(cell_r),
                        last: 1'b1};
          end else begin
            out_nxt = '{kind: KIND_DROPPED, found_id: '0, cell_index: out_cell(cell_r),
                        last: 1'b1};
          end
          state_nxt = S_IDLE;
        end
      end
      S_NB: begin
        i_nxt = '0;
        if (nb_ok) begin
          sel_nxt   = nb_cell;
          state_nxt = S_NBF;
        end else begin
          adv = 1'b1;
        end
      end
      S_NBF: begin
        if (fill_cur == '0) begin
          adv = 1'b1;
        end else begin
          state_nxt = S_ID;
        end
      end
      S_ID: begin
        // one-deep hold so the final id can carry last
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
          end
          pend_valid_nxt = 1'b1;
          pend_nxt = '{kind: KIND_NBR, found_id: ids_rdata, cell_index: out_cell(sel_r),
                       last: 1'b0};
          if (FILL_W'(i_r) + FILL_W'(1) < fill_cur) begin
            i_nxt = i_r + IDX_W'(1);
          end else begin
            adv = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt = '{kind: KIND_NONE, found_id: '0, cell_index: out_cell(cell_r),
                        last: 1'b1};
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step through the 3x3 offsets, row-major
    if (adv) begin
      if (dc_r == 2'd2) begin
        dc_nxt = 2'd0;
        if (dr_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          dr_nxt    = dr_r + 2'd1;
          state_nxt = S_NB;
        end
      end else begin
        dc_nxt    = dc_r + 2'd1;
        state_nxt = S_NB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      vld_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      vld_r        <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    id_r   <= id_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    cell_r <= cell_nxt;
    sel_r  <= sel_nxt;
    i_r    <= i_nxt;
    dr_r   <= dr_nxt;
    dc_r   <= dc_nxt;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  // read addresses come from next-state values, so data lines up with sel_r / i_r
  gbnq_ram #(
    .WIDTH (FILL_W),
    .DEPTH (CELL_TOTAL)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (sel_r),
    .wdata (fill_wdata),
    .raddr (sel_nxt),
    .rdata (fill_rdata)
  );

  gbnq_ram #(
    .WIDTH (ID_W),
    .DEPTH (ID_DEPTH)
  ) u_ids_ram (
    .clk   (clk),
    .we    (ids_we),
    .waddr (id_addr(sel_r, fill_cur)),
    .wdata (id_r),
    .raddr (id_addr(sel_nxt, FILL_W'(i_nxt))),
    .rdata (ids_rdata)
  );

endmodule

/* rtl/grid_bucket_neighbour_query_top.sv */
// ----------------------------------------------------------------------------
// grid_bucket_neighbour_query_top
// Uniform 2-D grid of id buckets with insert, clear and 3x3 neighbour query.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ---------------------------------
//   in_       in_valid / in_ready          in_data  (command, x, y, item_id)
//   out_      out_valid / out_ready        out_data (kind, found_id,
//                                                    cell_index, last)
//   cfg       psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One item at a time. Mapping a point registers the offset, then one 32x32
// multiply per axis. A query then steps through the 3x3 offsets, reads the
// fill of each in-grid cell, reads each stored id in turn and closes with a
// final result; the ids come through the single read port of the id memory.
// Synchronous active-low reset; fill memory needs no clearing pass, since
// per-cell valid flops mark buckets written since reset or the last clear.
// A full output register stalls the sequencer; the next item is taken
// while the last transfer of the previous one is still waiting.
//
module grid_bucket_neighbour_query_top
  import gbnq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input items
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // results
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_regs_t  cfg_r, cfg_nxt;
  shape_t     shape;
  pos_t       pos;
  logic       map_load;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  // ---- configuration registers ---------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_MIN_X:     cfg_nxt.min_x     = pwdata;
        REG_MIN_Y:     cfg_nxt.min_y     = pwdata;
        REG_ROW_SCALE: cfg_nxt.row_scale = pwdata;
        REG_COL_SCALE: cfg_nxt.col_scale = pwdata;
        REG_ROW_COUNT: cfg_nxt.row_count = pwdata[4:0];
        REG_COL_COUNT: cfg_nxt.col_count = pwdata[4:0];
        default:       cfg_nxt = cfg_r;   // unmapped: write ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_x     <= '0;
      cfg_r.min_y     <= '0;
      cfg_r.row_scale <= 32'h0001_0000;   // 1.0 in Q16.16
      cfg_r.col_scale <= 32'h0001_0000;
      cfg_r.row_count <= 5'd16;
      cfg_r.col_count <= 5'd16;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_X:     prdata = cfg_r.min_x;
      REG_MIN_Y:     prdata = cfg_r.min_y;
      REG_ROW_SCALE: prdata = cfg_r.row_scale;
      REG_COL_SCALE: prdata = cfg_r.col_scale;
      REG_ROW_COUNT: prdata = {27'd0, cfg_r.row_count};
      REG_COL_COUNT: prdata = {27'd0, cfg_r.col_count};
      default:       prdata = '0;
    endcase
  end

  // zero counts act as one, oversize counts saturate at the grid bounds
  assign shape.rows = eff_count(cfg_r.row_count, CNT_W'(GRID_ROWS));
  assign shape.cols = eff_count(cfg_r.col_count, CNT_W'(GRID_COLS));

  // ---- point to cell ---------------------------------------------------------
  gbnq_cell_map u_map (
    .clk   (clk),
    .load  (map_load),
    .x     (in_data.x),
    .y     (in_data.y),
    .cfg   (cfg_r),
    .shape (shape),
    .pos   (pos)
  );

  // ---- bucket memories and command sequencer --------------------------------
  gbnq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .shape     (shape),
    .pos       (pos),
    .map_load  (map_load)
  );

endmodule

/* dv/grid_query_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_query_scoreboard_pkg
// Scoreboard for the grid bucket block: keeps its own copy of the registers
// and buckets, works out the results of each command, checks the results.
// ----------------------------------------------------------------------------
package grid_query_sb_pkg;
  import gbnq_pkg::*;

  // the command code with no operation behind it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // rows or columns in use: zero acts as one, too many acts as the bound
  function automatic int grid_extent(input logic [4:0] cnt, input int bound);
    if (cnt == 5'd0) return 1;
    if (int'(cnt) > bound) return bound;
    return int'(cnt);
  endfunction

  class grid_query_scoreboard;
    logic signed [31:0] min_x     = '0;
    logic signed [31:0] min_y     = '0;
    logic [31:0]        row_scale = 32'd65536;
    logic [31:0]        col_scale = 32'd65536;
    logic [4:0]         row_count = 5'd16;
    logic [4:0]         col_count = 5'd16;

    int unsigned     fill_level [CELL_TOTAL];
    logic [ID_W-1:0] bucket_id  [ID_DEPTH];
    out_item_t       expected_results [$];
    int              error_count  = 0;
    int              result_count = 0;

    function void set_register(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
        REG_MIN_X:     min_x     = val;
        REG_MIN_Y:     min_y     = val;
        REG_ROW_SCALE: row_scale = val;
        REG_COL_SCALE: col_scale = val;
        REG_ROW_COUNT: row_count = val[4:0];
        REG_COL_COUNT: col_count = val[4:0];
        default: ;
      endcase
    endfunction

    // floor((coord - lo) * scale) with scale in Q16.16 and d in Q.20
    function int axis_slot(input logic signed [31:0] coord, input logic signed [31:0] lo,
                           input logic [31:0] scale, input int n);
      longint          d;
      longint unsigned p;
      d = longint'(coord) - longint'(lo);
      if (d <= 0) return 0;
      p = (longint'(d) * longint'({32'd0, scale})) >> 36;
      if (p > longint'(n - 1)) return n - 1;
      return int'(p);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // append one result to the expected stream
    function void queue_result(input out_item_t r);
      expected_results = {expected_results, r};
    endfunction

    function void note_command(input in_item_t cmd);
      int        rows, cols, r, c, home_cell, nr, nc, nb, dr, dc, k, hits;
      out_item_t res;
      rows      = grid_extent(row_count, GRID_ROWS);
      cols      = grid_extent(col_count, GRID_COLS);
      r         = axis_slot(cmd.x, min_x, row_scale, rows);
      c         = axis_slot(cmd.y, min_y, col_scale, cols);
      home_cell = r * cols + c;
      res  = '0;
      res.last = 1'b1;
      case (cmd.command)
        CMD_CLEAR: begin
          foreach (fill_level[i]) fill_level[i] = 0;
          res.kind = KIND_ACK;
          queue_result(res);
        end
        CMD_INSERT: begin
          res.cell_index = OCELL_W'(home_cell);
          if (fill_level[home_cell] < BUCKET_DEPTH) begin
            bucket_id[home_cell * BUCKET_DEPTH + fill_level[home_cell]] = cmd.item_id;
            fill_level[home_cell]++;
            res.kind = KIND_ACK;
          end else begin
            res.kind = KIND_DROPPED;
          end
          queue_result(res);
        end
        CMD_QUERY: begin
          hits = 0;
          for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
              nr = r + dr;
              nc = c + dc;
              if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
              nb = nr * cols + nc;
              for (k = 0; k < fill_level[nb]; k++) begin
                res.kind       = KIND_NBR;
                res.found_id   = bucket_id[nb * BUCKET_DEPTH + k];
                res.cell_index = OCELL_W'(nb);
                res.last       = 1'b0;
                queue_result(res);
                hits++;
              end
            end
          end
          if (hits == 0) begin
            res.kind       = KIND_NONE;
            res.cell_index = OCELL_W'(home_cell);
            queue_result(res);
          end else begin
            expected_results[expected_results.size() - 1].last = 1'b1;
          end
        end
        default: begin
          res.kind = KIND_ACK;
          queue_result(res);
        end
      endcase
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at result %0d: %s", result_count, what);
      error_count++;
    endtask

    function string diff_text(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      return $sformatf("%s got %0h expected %0h", field, got, want);
    endfunction

    task check_result(input out_item_t got);
      out_item_t want;
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %h cell %0d last %b",
                                  got.kind, got.found_id, got.cell_index, got.last));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind)
        report_mismatch(diff_text("kind", 32'(got.kind), 32'(want.kind)));
      if (got.found_id !== want.found_id)
        report_mismatch(diff_text("found_id", 32'(got.found_id), 32'(want.found_id)));
      if (got.cell_index !== want.cell_index)
        report_mismatch(diff_text("cell_index", 32'(got.cell_index), 32'(want.cell_index)));
      if (got.last !== want.last)
        report_mismatch(diff_text("last", 32'(got.last), 32'(want.last)));
    endtask
  endclass

endpackage

/* dv/tb_grid_bucket_neighbour_query_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_bucket_neighbour_query_top
// Drives clear, insert, query and unused commands into the grid bucket block
// under several grid setups and idle patterns; every result transfer is
// checked field by field against the scoreboard's own grid model.
// ----------------------------------------------------------------------------
module tb_grid_bucket_neighbour_query_top;
  import gbnq_pkg::*;
  import grid_query_sb_pkg::*;

  // one coordinate unit in Q12.20
  localparam logic [31:0] ONE = 32'h0010_0000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [CFG_DW-1:0] pwdata    = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // idle percentages of the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // coordinate window the random points are drawn from (a bit wider than
  // the grid so the clamps get hit too)
  logic [31:0] x_lo   = '0;
  logic [31:0] x_span = 32'h0100_0000;
  logic [31:0] y_lo   = '0;
  logic [31:0] y_span = 32'h0100_0000;

  grid_query_scoreboard grid_sb = new();

  grid_bucket_neighbour_query_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: ready is redrawn every cycle from the phase's stall rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: values read here are the ones from before the edge, since
  // everything on both sides of the ports moves by nonblocking assignment.
  // The result is handled before the input so a transfer accepted on the
  // same edge can never be matched against the item taken with it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) grid_sb.check_result(out_data);
      if (in_valid && in_ready) grid_sb.note_command(in_data);
    end
  end

  // Hard stop, far beyond the slowest legal run (all queries of 36 results
  // under heavy stalls would still finish well inside this).
  initial begin
    #7_200_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // One input transfer. Idle cycles come first; valid is left high on
  // return so back-to-back items keep it asserted.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every expected result has been transferred. The first edge
  // lets the monitor log an input accepted on the current edge.
  task automatic drain();
    do @(posedge clk); while (grid_sb.pending() != 0);
  endtask

  // APB write: setup then access. psel stays up between back-to-back writes.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    grid_sb.set_register(idx, val);
  endtask

  task automatic program_grid(input logic [31:0] mx, input logic [31:0] my,
                              input logic [31:0] rs, input logic [31:0] cs,
                              input logic [4:0] rc, input logic [4:0] cc);
    write_reg(REG_MIN_X, mx);
    write_reg(REG_MIN_Y, my);
    write_reg(REG_ROW_SCALE, rs);
    write_reg(REG_COL_SCALE, cs);
    write_reg(REG_ROW_COUNT, 32'(rc));
    write_reg(REG_COL_COUNT, 32'(cc));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t item_of(input logic [1:0] cmd, input logic [31:0] x,
                                       input logic [31:0] y, input logic [15:0] id);
    in_item_t it;
    it.command = cmd;
    it.x       = x;
    it.y       = y;
    it.item_id = id;
    return it;
  endfunction

  // Mostly inside the window, sometimes anywhere at all.
  function automatic logic [31:0] pick_coord(input logic [31:0] lo, input logic [31:0] span);
    if ($urandom_range(0, 99) < 12) return $urandom;
    return lo - (span >> 3) + $urandom_range(0, span + (span >> 2));
  endfunction

  // Inserts and queries dominate so buckets fill up and queries find them;
  // clears are rare to let state build up.
  function automatic in_item_t random_command();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2)       it.command = CMD_CLEAR;
    else if (pick < 7)  it.command = CMD_UNUSED;
    else if (pick < 55) it.command = CMD_INSERT;
    else                it.command = CMD_QUERY;
    it.x       = pick_coord(x_lo, x_span);
    it.y       = pick_coord(y_lo, y_span);
    it.item_id = ID_W'($urandom);
    return it;
  endfunction

  // count register value; one time in five a zero or an oversize count
  function automatic logic [4:0] pick_count();
    if ($urandom_range(0, 4) != 0) return 5'($urandom_range(1, 16));
    if ($urandom_range(0, 3) == 0) return 5'd0;
    return 5'($urandom_range(17, 31));
  endfunction

  // scale so that the whole span covers the cells in use
  function automatic logic [31:0] scale_for(input logic [4:0] cnt, input logic [31:0] span,
                                            input int bound);
    return 32'((64'(grid_extent(cnt, bound)) << 36) / 64'(span));
  endfunction

  // Random grid: random origin, random span, scale matched to the count.
  task automatic random_grid();
    logic [4:0] rc, cc;
    rc     = pick_count();
    cc     = pick_count();
    x_span = $urandom_range(32'h0000_4000, 32'h0400_0000);
    y_span = $urandom_range(32'h0000_4000, 32'h0400_0000);
    x_lo   = 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
    y_lo   = 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
    program_grid(x_lo, y_lo, scale_for(rc, x_span, GRID_ROWS),
                 scale_for(cc, y_span, GRID_COLS), rc, cc);
  endtask

  initial begin
    int ph;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset grid, 16x16 cells of one unit each ----
    // fill cell 0 to the brim, then one more insert is dropped
    send_item(item_of(CMD_INSERT, '0, '0, 16'hFFFF));
    send_item(item_of(CMD_INSERT, 32'h0008_0000, 32'h000C_0000, 16'h0001));
    send_item(item_of(CMD_INSERT, '0, '0, 16'h1234));
    send_item(item_of(CMD_INSERT, '0, '0, 16'h4321));
    send_item(item_of(CMD_INSERT, '0, '0, 16'h0000));
    // far corner clamps to the last cell, most negative point to row 0
    send_item(item_of(CMD_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000));
    send_item(item_of(CMD_INSERT, 32'h8000_0000, 3 * ONE, 16'h00A5));
    send_item(item_of(CMD_INSERT, ONE, ONE, 16'hAAAA));
    // queries: interior, corner, far corner, empty area, edge row
    send_item(item_of(CMD_QUERY, ONE, ONE, 16'h0000));
    send_item(item_of(CMD_QUERY, '0, '0, 16'hFFFF));
    send_item(item_of(CMD_QUERY, 32'h00FE_0000, 32'h00FE_0000, 16'h0000));
    send_item(item_of(CMD_QUERY, 8 * ONE, 8 * ONE, 16'h0000));
    send_item(item_of(CMD_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000));
    send_item(item_of(CMD_UNUSED, 5 * ONE, 9 * ONE, 16'h5A5A));
    // clear, then the old corner must be empty
    send_item(item_of(CMD_CLEAR, 7 * ONE, 7 * ONE, 16'h7777));
    send_item(item_of(CMD_QUERY, '0, '0, 16'h0000));
    send_item(item_of(CMD_INSERT, 32'h0028_0000, 32'h0038_0000, 16'h5555));
    send_item(item_of(CMD_QUERY, 3 * ONE, 3 * ONE, 16'h0000));
    in_valid <= 1'b0;

    // ---- random phases ----
    // Buckets are not cleared between phases, so a new row or column count
    // reads the old buckets under the new shape.
    for (ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: ;  // stay on the reset grid
        1: begin
          // extremes: lowest x origin with the largest scale and an oversize
          // row count, highest y origin with zero scale and a zero count
          x_lo   = 32'h8000_0000;
          x_span = 32'h0000_0200;
          y_lo   = 32'h7FFF_0000;
          y_span = 32'h0002_0000;
          program_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                       5'd31, 5'd0);
        end
        2: begin
          // a single row of sixteen columns
          x_lo   = '0;
          x_span = 4 * ONE;
          y_lo   = -(8 * ONE);
          y_span = 16 * ONE;
          program_grid('0, -(8 * ONE), 32'd65536, 32'd65536, 5'd1, 5'd16);
        end
        default: random_grid();
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      repeat (60) send_item(random_command());
      in_valid <= 1'b0;
    end

    // let anything stray show up before the verdict
    drain();
    repeat (80) @(posedge clk);
    if (grid_sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
